[design/epsilon_nfa_closure_move_macros.svh]
// Assertion macros shared by the RTL of the epsilon-NFA closure/move block.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef EPSILON_NFA_CLOSURE_MOVE_MACROS_SVH
`define EPSILON_NFA_CLOSURE_MOVE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ENFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ENFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/enfa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package enfa_pkg;

  // Letter states a..z, one bit each in a state set
  localparam int NUM_STATES      = 26;
  localparam int SET_W           = NUM_STATES;
  localparam int ST_W            = 5;
  localparam int SYM_W           = 8;
  localparam int MAX_TRANSITIONS = 64;
  localparam int IDX_W           = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
  localparam int CNT_W           = $clog2(MAX_TRANSITIONS + 1);

  typedef logic [SET_W-1:0] set_t;
  typedef logic [ST_W-1:0]  st_idx_t;
  typedef logic [SYM_W-1:0] sym_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] tbl_idx_t;

  localparam sym_t    EPS_SYMBOL = 8'd101;
  localparam st_idx_t LAST_STATE = ST_W'(NUM_STATES - 1);
  localparam cnt_t    MAX_CNT    = CNT_W'(MAX_TRANSITIONS);

  typedef enum logic [0:0] {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  // One stored transition: from, symbol, to
  typedef struct packed {
    st_idx_t from_state;
    sym_t    symbol;
    st_idx_t to_state;
  } tbl_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLOS_Q,
    ST_SCAN,
    ST_CLOS_T,
    ST_FINISH
  } fsm_t;

endpackage

`default_nettype wire

[design/enfa_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none

// Command channel
interface enfa_in_if;
  logic              valid;
  logic              ready;
  enfa_pkg::cmd_t    cmd;
  enfa_pkg::st_idx_t from_state;
  enfa_pkg::sym_t    symbol;
  enfa_pkg::st_idx_t to_state;

  modport source (output valid, cmd, from_state, symbol, to_state, input ready);
  modport sink   (input valid, cmd, from_state, symbol, to_state, output ready);
endinterface

// Result channel
interface enfa_out_if;
  logic           valid;
  logic           ready;
  enfa_pkg::set_t closure_set;
  enfa_pkg::set_t move_set;
  logic           table_full;

  modport source (output valid, closure_set, move_set, table_full, input ready);
  modport sink   (input valid, closure_set, move_set, table_full, output ready);
endinterface

// Register write channel (declared_states)
interface enfa_cfg_if;
  logic           valid;
  logic           ready;
  enfa_pkg::set_t declared_states;

  modport source (output valid, declared_states, input ready);
  modport sink   (input valid, declared_states, output ready);
endinterface

`default_nettype wire

[design/epsilon_nfa_closure_move.sv]
`timescale 1ns / 1ps
`default_nettype none
// Epsilon-NFA closure and move unit over the letter states a..z.
// in_ch: one command per transaction. An add (cmd 0) stores a transition and,
//   for symbol 'e', an epsilon edge. A query (cmd 1) asks for the epsilon
//   closure of from_state and the move set on symbol.
// out_ch: one result per command: closure_set, move_set, table_full.
// cfg_ch: writes declared_states; always ready, write only while idle.
// Sequence: an add goes through ST_FINISH to the output register. A query
//   walks the closure one state per cycle, scans the stored transitions one
//   per cycle through the table's read port, then walks the target closure.
//   An epsilon-symbol query skips the scan and target walk.
// Throughput: one command at a time; in_ch.ready is high only while idle.
//   The output register lets the next command be taken while a result waits.
// Stall: a finished result holds in the FSM until the output register is free.
// Reset (synchronous, rst_n low): adjacency and transition count cleared,
//   declared_states set to all ones, no result pending.
`include "epsilon_nfa_closure_move_macros.svh"

module epsilon_nfa_closure_move (
  input  wire logic   clk,
  input  wire logic   rst_n,
  enfa_in_if.sink     in_ch,
  enfa_out_if.source  out_ch,
  enfa_cfg_if.sink    cfg_ch
);

  // Index of the lowest set bit of a state set
  function automatic enfa_pkg::st_idx_t low_idx(enfa_pkg::set_t s);
    enfa_pkg::set_t    iso;
    enfa_pkg::st_idx_t idx;
    iso = s & (~s + 1'b1);
    idx = '0;
    for (int k = 0; k < enfa_pkg::NUM_STATES; k++) begin
      if (iso[k]) idx = idx | enfa_pkg::ST_W'(k);
    end
    return idx;
  endfunction

  enfa_pkg::fsm_t       state_r, state_nxt;
  enfa_pkg::set_t       declared_r;
  enfa_pkg::set_t       adj_r [enfa_pkg::NUM_STATES];
  enfa_pkg::tbl_entry_t tbl_mem [enfa_pkg::MAX_TRANSITIONS];
  enfa_pkg::tbl_entry_t ent_r;
  enfa_pkg::cnt_t       count_r, count_nxt;
  enfa_pkg::cnt_t       rd_idx_r, rd_idx_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic                 rd_en;
  enfa_pkg::set_t       frontier_r, frontier_nxt;
  enfa_pkg::set_t       visited_r, visited_nxt;
  enfa_pkg::set_t       targets_r, targets_nxt;
  enfa_pkg::sym_t       qsym_r, qsym_nxt;
  enfa_pkg::set_t       res_cl_r, res_cl_nxt;
  enfa_pkg::set_t       res_mv_r, res_mv_nxt;
  logic                 res_full_r, res_full_nxt;
  logic                 out_valid_r, out_valid_nxt;
  enfa_pkg::set_t       out_cl_r, out_mv_r;
  logic                 out_full_r;
  logic                 in_ready;
  logic                 tbl_we;
  logic                 adj_we;
  logic                 out_load;
  enfa_pkg::st_idx_t    cur_k;
  enfa_pkg::set_t       row;
  enfa_pkg::set_t       new_bits;
  enfa_pkg::set_t       start_set;
  logic                 ent_match;
  enfa_pkg::set_t       ent_tgt;
  enfa_pkg::tbl_entry_t wr_ent;

  // Handshake outputs
  assign in_ch.ready        = in_ready;
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.closure_set = out_cl_r;
  assign out_ch.move_set    = out_mv_r;
  assign out_ch.table_full  = out_full_r;

  // Shared closure-walk datapath: expand the lowest pending state
  assign cur_k    = low_idx(frontier_r);
  assign row      = adj_r[cur_k];
  assign new_bits = row & ~visited_r;

  // Query start: the state itself if declared; shift beyond z gives empty
  assign start_set = (enfa_pkg::set_t'(1) << in_ch.from_state) & declared_r;

  // Scan compare on the registered table entry
  assign ent_match = (|((enfa_pkg::set_t'(1) << ent_r.from_state) & res_cl_r)) &&
                     (ent_r.symbol == qsym_r);
  assign ent_tgt   = (enfa_pkg::set_t'(1) << ent_r.to_state) & declared_r;

  assign wr_ent.from_state = in_ch.from_state;
  assign wr_ent.symbol     = in_ch.symbol;
  assign wr_ent.to_state   = in_ch.to_state;

  // Sequencer: next state and datapath controls
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    rd_idx_nxt   = rd_idx_r;
    rd_vld_nxt   = 1'b0;
    rd_en        = 1'b0;
    frontier_nxt = frontier_r;
    visited_nxt  = visited_r;
    targets_nxt  = targets_r;
    qsym_nxt     = qsym_r;
    res_cl_nxt   = res_cl_r;
    res_mv_nxt   = res_mv_r;
    res_full_nxt = res_full_r;
    tbl_we       = 1'b0;
    adj_we       = 1'b0;
    out_load     = 1'b0;
    in_ready     = 1'b0;
    unique case (state_r)
      enfa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.cmd == enfa_pkg::CMD_ADD) begin
            res_cl_nxt = '0;
            res_mv_nxt = '0;
            if (count_r == enfa_pkg::MAX_CNT) begin
              res_full_nxt = 1'b1;
            end else begin
              res_full_nxt = 1'b0;
              tbl_we       = 1'b1;
              count_nxt    = count_r + 1'b1;
              adj_we       = (in_ch.symbol == enfa_pkg::EPS_SYMBOL) &&
                             (in_ch.from_state <= enfa_pkg::LAST_STATE) &&
                             (in_ch.to_state <= enfa_pkg::LAST_STATE);
            end
            state_nxt = enfa_pkg::ST_FINISH;
          end else begin
            qsym_nxt     = in_ch.symbol;
            res_full_nxt = 1'b0;
            visited_nxt  = start_set;
            frontier_nxt = start_set;
            state_nxt    = enfa_pkg::ST_CLOS_Q;
          end
        end
      end
      enfa_pkg::ST_CLOS_Q, enfa_pkg::ST_CLOS_T: begin
        if (frontier_r == '0) begin
          if (state_r == enfa_pkg::ST_CLOS_Q) begin
            res_cl_nxt = visited_r;
            if (qsym_r == enfa_pkg::EPS_SYMBOL) begin
              res_mv_nxt = '0;
              state_nxt  = enfa_pkg::ST_FINISH;
            end else begin
              rd_idx_nxt  = '0;
              targets_nxt = '0;
              state_nxt   = enfa_pkg::ST_SCAN;
            end
          end else begin
            res_mv_nxt = visited_r;
            state_nxt  = enfa_pkg::ST_FINISH;
          end
        end else begin
          visited_nxt  = visited_r | row;
          frontier_nxt = (frontier_r & ~(enfa_pkg::set_t'(1) << cur_k)) | new_bits;
        end
      end
      enfa_pkg::ST_SCAN: begin
        if (rd_vld_r && ent_match) targets_nxt = targets_r | ent_tgt;
        if (rd_idx_r != count_r) begin
          rd_en      = 1'b1;
          rd_idx_nxt = rd_idx_r + 1'b1;
          rd_vld_nxt = 1'b1;
        end else if (!rd_vld_r) begin
          visited_nxt  = targets_r;
          frontier_nxt = targets_r;
          state_nxt    = enfa_pkg::ST_CLOS_T;
        end
      end
      enfa_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = enfa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = enfa_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= enfa_pkg::ST_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Declared-state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      declared_r <= '1;
    end else if (cfg_ch.valid) begin
      declared_r <= cfg_ch.declared_states;
    end
  end

  // Epsilon adjacency rows, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < enfa_pkg::NUM_STATES; i++) adj_r[i] <= '0;
    end else if (adj_we) begin
      adj_r[in_ch.from_state] <= adj_r[in_ch.from_state] |
                                 (enfa_pkg::set_t'(1) << in_ch.to_state);
    end
  end

  // Transition table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[count_r[enfa_pkg::IDX_W-1:0]] <= wr_ent;
    if (rd_en)  ent_r <= tbl_mem[rd_idx_r[enfa_pkg::IDX_W-1:0]];
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    frontier_r <= frontier_nxt;
    visited_r  <= visited_nxt;
    targets_r  <= targets_nxt;
    qsym_r     <= qsym_nxt;
    res_cl_r   <= res_cl_nxt;
    res_mv_r   <= res_mv_nxt;
    res_full_r <= res_full_nxt;
    if (out_load) begin
      out_cl_r   <= res_cl_r;
      out_mv_r   <= res_mv_r;
      out_full_r <= res_full_r;
    end
  end

  // Checks
  `ENFA_ASSERT_NOW(a_frontier_in_visited, state_r == enfa_pkg::ST_CLOS_Q || state_r == enfa_pkg::ST_CLOS_T, (frontier_r & ~visited_r) == '0, "closure frontier holds an unvisited state")
  `ENFA_ASSERT_NOW(a_count_bound, 1'b1, count_r <= enfa_pkg::MAX_CNT, "transition count beyond table size")
  `ENFA_ASSERT_NEXT(a_count_inc, in_ch.valid && in_ready && in_ch.cmd == enfa_pkg::CMD_ADD && count_r != enfa_pkg::MAX_CNT, count_r == $past(count_r) + 1'b1, "stored add did not advance count")
  `ENFA_ASSERT_NOW(a_full_empty_sets, out_valid_r && out_full_r, out_cl_r == '0 && out_mv_r == '0, "dropped add reports nonzero sets")

endmodule

`default_nettype wire

[dv/tb_epsilon_nfa_closure_move.sv]
`timescale 1ns / 1ps

module tb_epsilon_nfa_closure_move;

  // One result transaction as predicted
  typedef struct packed {
    enfa_pkg::set_t closure_set;
    enfa_pkg::set_t move_set;
    logic           table_full;
  } nfa_result_t;

  // Symbols used by the directed and random stimulus
  localparam enfa_pkg::sym_t SYM_X   = 8'd120;   // 'x'
  localparam enfa_pkg::sym_t SYM_LO  = 8'd48;    // '0'
  localparam enfa_pkg::sym_t SYM_HI  = 8'd51;    // '3'
  localparam enfa_pkg::sym_t SYM_TOP = 8'd255;

  // Letter states and out-of-range indexes
  localparam enfa_pkg::st_idx_t ST_A      = 5'd0;
  localparam enfa_pkg::st_idx_t ST_B      = 5'd1;
  localparam enfa_pkg::st_idx_t ST_C      = 5'd2;
  localparam enfa_pkg::st_idx_t ST_D      = 5'd3;
  localparam enfa_pkg::st_idx_t ST_E      = 5'd4;
  localparam enfa_pkg::st_idx_t ST_Y      = 5'd24;
  localparam enfa_pkg::st_idx_t ST_Z      = 5'd25;
  localparam enfa_pkg::st_idx_t ST_OUT    = 5'd26;
  localparam enfa_pkg::st_idx_t ST_MAXIDX = 5'd31;

  localparam enfa_pkg::set_t ALL_DECLARED = '1;

  logic clk;
  logic rst_n;
  int   err_cnt;
  bit   no_idle;

  enfa_in_if  in_ch ();
  enfa_out_if out_ch ();
  enfa_cfg_if cfg_ch ();

  epsilon_nfa_closure_move uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state: declared mask, epsilon edges, stored transitions
  enfa_pkg::set_t       model_declared;
  enfa_pkg::set_t       eps_adj [enfa_pkg::NUM_STATES];
  enfa_pkg::tbl_entry_t stored_trans [$];
  nfa_result_t          pending_results [$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Epsilon closure of one state; edges out of undeclared states still count
  function automatic enfa_pkg::set_t eps_closure(enfa_pkg::st_idx_t q);
    enfa_pkg::set_t reach;
    enfa_pkg::set_t grown;
    if (q > enfa_pkg::LAST_STATE || !model_declared[q]) return '0;
    reach = enfa_pkg::set_t'(1) << q;
    grown = '0;
    while (grown != reach) begin
      grown = reach;
      for (int k = 0; k < enfa_pkg::NUM_STATES; k++)
        if (grown[k]) reach |= eps_adj[k];
    end
    return reach;
  endfunction

  // Apply one command to the predictor and return the result it produces
  function automatic nfa_result_t apply_cmd(enfa_pkg::cmd_t c, enfa_pkg::st_idx_t f,
                                            enfa_pkg::sym_t s, enfa_pkg::st_idx_t t);
    nfa_result_t r;
    r = '0;
    if (c == enfa_pkg::CMD_ADD) begin
      if (stored_trans.size() >= enfa_pkg::MAX_TRANSITIONS) begin
        r.table_full = 1'b1;
      end else begin
        stored_trans.push_back('{from_state: f, symbol: s, to_state: t});
        if (s == enfa_pkg::EPS_SYMBOL && f <= enfa_pkg::LAST_STATE &&
            t <= enfa_pkg::LAST_STATE) eps_adj[f][t] = 1'b1;
      end
    end else begin
      r.closure_set = eps_closure(f);
      if (s != enfa_pkg::EPS_SYMBOL) begin
        foreach (stored_trans[i]) begin
          if (stored_trans[i].from_state <= enfa_pkg::LAST_STATE &&
              r.closure_set[stored_trans[i].from_state] &&
              stored_trans[i].symbol == s)
            r.move_set |= eps_closure(stored_trans[i].to_state);
        end
      end
    end
    return r;
  endfunction

  // Result sink backpressure
  always @(posedge clk) begin
    if (no_idle) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= 25);
    end
  end

  // Compare every result transaction with the oldest prediction
  always @(posedge clk) begin : chk_results
    nfa_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no prediction pending");
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.closure_set !== want.closure_set) begin
          $error("closure_set: expected %h, got %h", want.closure_set, out_ch.closure_set);
          err_cnt++;
        end
        if (out_ch.move_set !== want.move_set) begin
          $error("move_set: expected %h, got %h", want.move_set, out_ch.move_set);
          err_cnt++;
        end
        if (out_ch.table_full !== want.table_full) begin
          $error("table_full: expected %b, got %b", want.table_full, out_ch.table_full);
          err_cnt++;
        end
      end
    end
  end

  // Send one command transaction, at times with a random gap ahead of it
  task automatic send_cmd(enfa_pkg::cmd_t c, enfa_pkg::st_idx_t f, enfa_pkg::sym_t s,
                          enfa_pkg::st_idx_t t);
    if (!no_idle && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= c;
    in_ch.from_state <= f;
    in_ch.symbol     <= s;
    in_ch.to_state   <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(apply_cmd(c, f, s, t));
  endtask

  task automatic add_trans(enfa_pkg::st_idx_t f, enfa_pkg::sym_t s, enfa_pkg::st_idx_t t);
    send_cmd(enfa_pkg::CMD_ADD, f, s, t);
  endtask

  task automatic query(enfa_pkg::st_idx_t q, enfa_pkg::sym_t s);
    send_cmd(enfa_pkg::CMD_QUERY, q, s, enfa_pkg::st_idx_t'($urandom_range(31)));
  endtask

  // Random command: mostly letter states and a small alphabet, some noise
  task automatic send_random(int add_pct);
    enfa_pkg::cmd_t    c;
    enfa_pkg::st_idx_t f;
    enfa_pkg::st_idx_t t;
    enfa_pkg::sym_t    s;
    c = ($urandom_range(99) < add_pct) ? enfa_pkg::CMD_ADD : enfa_pkg::CMD_QUERY;
    f = ($urandom_range(9) == 0) ? enfa_pkg::st_idx_t'($urandom_range(31, 26))
                                 : enfa_pkg::st_idx_t'($urandom_range(25));
    t = ($urandom_range(9) == 0) ? enfa_pkg::st_idx_t'($urandom_range(31, 26))
                                 : enfa_pkg::st_idx_t'($urandom_range(25));
    case ($urandom_range(9))
      0, 1, 2: s = enfa_pkg::EPS_SYMBOL;
      3, 4:    s = enfa_pkg::sym_t'($urandom_range(255));
      default: s = enfa_pkg::sym_t'($urandom_range(SYM_HI, SYM_LO));
    endcase
    send_cmd(c, f, s, t);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_declared(enfa_pkg::set_t mask);
    wait_idle();
    cfg_ch.valid           <= 1'b1;
    cfg_ch.declared_states <= mask;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    model_declared = mask;
  endtask

  task automatic random_phase(int n, int add_pct);
    for (int i = 0; i < n; i++) send_random(add_pct);
  endtask

  // Empty table: closure is the state itself, no moves; high indexes give nothing
  task automatic test_empty_table();
    query(ST_A, SYM_X);
    query(ST_Z, enfa_pkg::EPS_SYMBOL);
    query(ST_OUT, 8'd0);
    query(ST_MAXIDX, SYM_TOP);
  endtask

  // Chained epsilon edges, a plain move, out-of-range states, a duplicate
  task automatic test_transitions();
    add_trans(ST_A, enfa_pkg::EPS_SYMBOL, ST_B);
    add_trans(ST_B, enfa_pkg::EPS_SYMBOL, ST_C);
    add_trans(ST_C, SYM_X, ST_D);
    add_trans(ST_D, enfa_pkg::EPS_SYMBOL, ST_E);
    add_trans(ST_Z, SYM_TOP, ST_A);
    add_trans(ST_MAXIDX, enfa_pkg::EPS_SYMBOL, ST_A);
    add_trans(ST_A, enfa_pkg::EPS_SYMBOL, ST_MAXIDX);
    add_trans(ST_C, SYM_X, ST_D);
    add_trans(ST_Y, 8'd0, ST_OUT);
    query(ST_A, SYM_X);
    query(ST_Z, SYM_TOP);
    query(ST_A, enfa_pkg::EPS_SYMBOL);
    query(ST_Y, 8'd0);
    query(ST_MAXIDX, enfa_pkg::EPS_SYMBOL);
  endtask

  // Undeclared states: empty closure of their own, but still passed through
  task automatic test_undeclared();
    write_declared(ALL_DECLARED & ~(enfa_pkg::set_t'(1) << ST_B));
    query(ST_A, SYM_X);
    query(ST_B, SYM_X);
    write_declared('0);
    query(ST_A, SYM_X);
    write_declared(ALL_DECLARED);
  endtask

  // Random traffic while the table fills up
  task automatic test_random_fill();
    random_phase(300, 25);
  endtask

  // Adds beyond the table size are dropped and flagged
  task automatic test_table_full();
    while (stored_trans.size() < enfa_pkg::MAX_TRANSITIONS) send_random(100);
    add_trans(ST_A, enfa_pkg::EPS_SYMBOL, ST_Z);
    add_trans(ST_MAXIDX, SYM_TOP, ST_MAXIDX);
    query(ST_A, SYM_X);
  endtask

  task automatic test_none_declared();
    write_declared('0);
    random_phase(100, 10);
  endtask

  // All declared, first half with no idling on either side
  task automatic test_all_declared();
    write_declared(ALL_DECLARED);
    no_idle = 1'b1;
    random_phase(150, 10);
    no_idle = 1'b0;
    random_phase(150, 10);
  endtask

  // Dense, sparse and plain random declared masks
  task automatic test_declared_masks();
    enfa_pkg::set_t mask;
    for (int p = 0; p < 4; p++) begin
      case ($urandom_range(2))
        0:       mask = enfa_pkg::set_t'($urandom);
        1:       mask = enfa_pkg::set_t'($urandom | $urandom);
        default: mask = enfa_pkg::set_t'($urandom & $urandom);
      endcase
      write_declared(mask);
      random_phase(300, 10);
    end
  endtask

  initial begin
    in_ch.valid            = 1'b0;
    in_ch.cmd              = enfa_pkg::CMD_ADD;
    in_ch.from_state       = '0;
    in_ch.symbol           = '0;
    in_ch.to_state         = '0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.declared_states = '0;
    rst_n                  = 1'b0;
    err_cnt                = 0;
    no_idle                = 1'b0;
    model_declared         = ALL_DECLARED;
    foreach (eps_adj[i]) eps_adj[i] = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_transitions();
    test_undeclared();
    test_random_fill();
    test_table_full();
    test_none_declared();
    test_all_declared();
    test_declared_masks();

    // Drain, then allow the longest query time for stray results
    wait_idle();
    repeat (130) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d predicted results never arrived", pending_results.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/enfa_pkg.sv
design/enfa_ifs.sv
design/epsilon_nfa_closure_move.sv
dv/tb_epsilon_nfa_closure_move.sv
